// ===== hdl/dsrsg_pkg.sv =====
`timescale 1ns / 1ps
package dsrsg_pkg;
  localparam int unsigned PeriodWidth   = 20;
  localparam int unsigned VelocityWidth = 17;
  localparam int unsigned RateWidth     = 20;
  localparam int unsigned DivWidth      = 21;
  localparam int unsigned DivCountWidth = 5;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 20;

  localparam logic [CfgIdxWidth-1:0] RegMaxVelocity  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegStepRate     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegAccelStep    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegRampDivider  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegDirSetup     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegPanInvert    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegTiltInvert   = 3'd6;

  typedef struct packed {
    logic [15:0]           max_velocity;
    logic [RateWidth-1:0]  step_rate;
    logic [9:0]            accel_step;
    logic [15:0]           ramp_divider;
    logic [7:0]            setup_hold;
    logic                  pan_invert;
    logic                  tilt_invert;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ramp_due;
  } status_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StFin  = 4'b0100,
    StOut  = 4'b1000
  } state_e;
endpackage

// ===== hdl/dsrsg_ctrl.sv =====
`timescale 1ns / 1ps
module dsrsg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  dsrsg_pkg::status_t  status_i,
  output dsrsg_pkg::cmd_t     cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);
  dsrsg_pkg::state_e state_q, state_d;
  logic [dsrsg_pkg::DivCountWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dsrsg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tick = 1'b1;
          if (status_i.ramp_due) begin
            cmd_o.div_start = 1'b1;
            cnt_d = '0;
            state_d = dsrsg_pkg::StDiv;
          end else begin
            state_d = dsrsg_pkg::StOut;
          end
        end
      end
      dsrsg_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dsrsg_pkg::DivCountWidth'(dsrsg_pkg::DivWidth - 1)) begin
          state_d = dsrsg_pkg::StFin;
        end
      end
      dsrsg_pkg::StFin: begin
        cmd_o.finish = 1'b1;
        state_d = dsrsg_pkg::StOut;
      end
      dsrsg_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = dsrsg_pkg::StIdle;
        end
      end
      default: state_d = dsrsg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsrsg_pkg::StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == dsrsg_pkg::StDiv)
    else $error("divider not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsrsg_pkg::StFin |=> out_valid_o)
    else $error("result not shown after finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accept while result pending");
endmodule

// ===== hdl/dsrsg_axis.sv =====
`timescale 1ns / 1ps
module dsrsg_axis (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dsrsg_pkg::cmd_t                         cmd_i,
  input  logic                                    ramp_i,
  input  logic                                    stop_i,
  input  logic signed [dsrsg_pkg::VelocityWidth-1:0] target_i,
  input  logic                                    invert_i,
  input  dsrsg_pkg::cfg_t                         cfg_i,
  output logic                                    step_o,
  output logic                                    dir_o,
  output logic signed [dsrsg_pkg::VelocityWidth-1:0] speed_o
);
  localparam int unsigned VW = dsrsg_pkg::VelocityWidth;
  localparam int unsigned PW = dsrsg_pkg::PeriodWidth;
  localparam int unsigned DW = dsrsg_pkg::DivWidth;

  logic [PW-1:0] period_q, period_d, phase_q, phase_d;
  logic signed [VW-1:0] speed_q, speed_d;
  logic [7:0] hold_q, hold_d;
  logic dir_q, dir_d, step_q, step_d;
  logic upd_q, upd_d;
  logic [DW-1:0] num_q, num_d, rem_q, rem_d;
  logic [VW-1:0] mag_q, mag_d;
  logic [DW:0] trial;

  logic signed [VW+1:0] cur, tgt, diff, stp, nxt, lim, acc;
  logic [PW-1:0] ph0, p_new;
  logic [7:0] h0;
  logic s0, dnew;

  assign trial = {rem_q, num_q[DW-1]} - {1'b0, {(DW-VW){1'b0}}, mag_q};

  always_comb begin
    period_d = period_q; phase_d = phase_q; speed_d = speed_q;
    hold_d = hold_q; dir_d = dir_q; step_d = step_q; upd_d = upd_q;
    num_d = num_q; rem_d = rem_q; mag_d = mag_q;
    cur = '0; tgt = '0; diff = '0; stp = '0; nxt = '0; lim = '0; acc = '0;
    ph0 = phase_q; h0 = hold_q; s0 = step_q; dnew = 1'b0; p_new = '0;
    if (cmd_i.tick) begin
      upd_d = 1'b0;
      if (stop_i) begin
        speed_d = '0;
        period_d = '0;
        s0 = 1'b0;
      end
      if (hold_q != 8'd0) begin
        h0 = hold_q - 8'd1;
        s0 = 1'b0;
      end else if (period_d != '0) begin
        if (phase_q == PW'(0)) s0 = 1'b1;
        else if (phase_q == PW'(1)) s0 = 1'b0;
        ph0 = (phase_q + PW'(1) >= period_d) ? '0 : phase_q + PW'(1);
      end
      hold_d = h0; step_d = s0; phase_d = ph0;
      if (ramp_i) begin
        cur = (VW+2)'(speed_d);
        tgt = stop_i ? '0 : (VW+2)'(target_i);
        if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) tgt = '0;
        if (cur != tgt) begin
          lim = (VW+2)'({1'b0, cfg_i.max_velocity});
          acc = (VW+2)'({1'b0, cfg_i.accel_step});
          diff = tgt - cur;
          stp = (diff > 0) ? acc : -acc;
          if ((diff > 0 && stp > diff) || (diff < 0 && stp < diff)) stp = diff;
          nxt = cur + stp;
          if ((cur > 0 && nxt < 0) || (cur < 0 && nxt > 0)) nxt = '0;
          if (nxt > lim) nxt = lim;
          if (nxt < -lim) nxt = -lim;
          speed_d = VW'(nxt);
          if (nxt == 0) begin
            period_d = '0; phase_d = '0; step_d = 1'b0;
          end else begin
            dnew = (nxt > 0) ^ invert_i;
            if (dnew != dir_q) begin
              step_d = 1'b0; phase_d = '0; hold_d = cfg_i.setup_hold;
            end
            dir_d = dnew;
            mag_d = VW'((nxt > 0) ? nxt : -nxt);
            upd_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.div_start) begin
      num_d = DW'(cfg_i.step_rate) + DW'(mag_d >> 1);
      rem_d = '0;
    end
    if (cmd_i.div_step) begin
      if (!trial[DW]) rem_d = trial[DW-1:0];
      else rem_d = {rem_q[DW-2:0], num_q[DW-1]};
      num_d = {num_q[DW-2:0], !trial[DW]};
    end
    if (cmd_i.finish && upd_q) begin
      p_new = (num_q < DW'(2)) ? PW'(2) : PW'(num_q);
      period_d = p_new;
      if (phase_q >= p_new) phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0; phase_q <= '0; speed_q <= '0;
      hold_q <= '0; dir_q <= 1'b0; step_q <= 1'b0; upd_q <= 1'b0;
    end else begin
      period_q <= period_d; phase_q <= phase_d; speed_q <= speed_d;
      hold_q <= hold_d; dir_q <= dir_d; step_q <= step_d; upd_q <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; mag_q <= mag_d;
  end

  assign step_o = step_q;
  assign dir_o = dir_q;
  assign speed_o = speed_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q == '0 |-> period_q == '0)
    else $error("period live at zero speed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != 8'd0 |-> !step_q)
    else $error("step high during hold");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != '0 |-> phase_q < period_q)
    else $error("phase beyond period");
endmodule

// ===== hdl/dsrsg_datapath.sv =====
`timescale 1ns / 1ps
module dsrsg_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dsrsg_pkg::cmd_t                          cmd_i,
  output dsrsg_pkg::status_t                       status_o,
  input  logic                                     cfg_we_i,
  input  logic [dsrsg_pkg::CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [dsrsg_pkg::CfgDataWidth-1:0]       cfg_data_i,
  input  logic [39:0]                              in_data_i,
  output logic [39:0]                              out_data_o
);
  localparam int unsigned VW = dsrsg_pkg::VelocityWidth;
  dsrsg_pkg::cfg_t cfg_q;
  logic [15:0] ramp_q, ramp_inc;
  logic ramp_q_due, ramp_hit_q;
  logic p_step, p_dir, t_step, t_dir;
  logic signed [VW-1:0] p_vel, t_vel, p_tgt, t_tgt;
  logic stop;

  assign p_tgt = in_data_i[VW-1:0];
  assign t_tgt = in_data_i[2*VW-1:VW];
  assign stop = in_data_i[2*VW];
  assign ramp_inc = ramp_q + 16'd1;
  assign ramp_q_due = ramp_inc >= cfg_q.ramp_divider;
  assign status_o.ramp_due = ramp_q_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_velocity <= 16'd20000;
      cfg_q.step_rate <= 20'd100000;
      cfg_q.accel_step <= 10'd1;
      cfg_q.ramp_divider <= 16'd20;
      cfg_q.setup_hold <= 8'd5;
      cfg_q.pan_invert <= 1'b0;
      cfg_q.tilt_invert <= 1'b1;
      ramp_q <= '0;
      ramp_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dsrsg_pkg::RegMaxVelocity: cfg_q.max_velocity <= cfg_data_i[15:0];
          dsrsg_pkg::RegStepRate: cfg_q.step_rate <= cfg_data_i;
          dsrsg_pkg::RegAccelStep: cfg_q.accel_step <= cfg_data_i[9:0];
          dsrsg_pkg::RegRampDivider: cfg_q.ramp_divider <= cfg_data_i[15:0];
          dsrsg_pkg::RegDirSetup: cfg_q.setup_hold <= cfg_data_i[7:0];
          dsrsg_pkg::RegPanInvert: cfg_q.pan_invert <= cfg_data_i[0];
          dsrsg_pkg::RegTiltInvert: cfg_q.tilt_invert <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        ramp_q <= ramp_q_due ? 16'd0 : ramp_inc;
        ramp_hit_q <= ramp_q_due;
      end
    end
  end

  dsrsg_axis u_pan (
    .clk_i, .rst_ni, .cmd_i, .ramp_i(ramp_q_due), .stop_i(stop), .target_i(p_tgt),
    .invert_i(cfg_q.pan_invert), .cfg_i(cfg_q), .step_o(p_step), .dir_o(p_dir),
    .speed_o(p_vel));
  dsrsg_axis u_tilt (
    .clk_i, .rst_ni, .cmd_i, .ramp_i(ramp_q_due), .stop_i(stop), .target_i(t_tgt),
    .invert_i(cfg_q.tilt_invert), .cfg_i(cfg_q), .step_o(t_step), .dir_o(t_dir),
    .speed_o(t_vel));

  assign out_data_o = {2'b00, t_vel, p_vel, t_dir, t_step, p_dir, p_step};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> cmd_i.tick && ramp_q_due)
    else $error("divide without ramp tick");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> ramp_hit_q && ramp_q == 16'd0)
    else $error("ramp count not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick && stop |=> p_vel == '0 || ramp_hit_q)
    else $error("hard stop ignored");
endmodule

// ===== hdl/dual_stepper_ramp_step_generator.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload
// s_axis   in   tdata: pan_target[16:0], tilt_target[33:17], hard_stop[34]
// m_axis   out  tdata: pan_step, pan_dir, tilt_step, tilt_dir, pan_vel, tilt_vel
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
// A tick with no ramp update goes straight to the result; a ramp tick first
// runs the 21-step restoring divider in each axis unit, both run at once.
// One tick is in flight; s_axis_tready drops until the result transfers.
// Reset is asynchronous; it clears all state but the divider registers and loads register defaults.
module dual_stepper_ramp_step_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // pan_target, tilt_target, hard_stop
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pan_step, pan_dir, tilt_step, tilt_dir,
                                     // pan_velocity, tilt_velocity
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);
  dsrsg_pkg::cmd_t cmd;
  dsrsg_pkg::status_t status;

  dsrsg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid));

  dsrsg_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .in_data_i(s_axis_tdata), .out_data_o(m_axis_tdata));
endmodule

// ===== tb/dual_stepper_ramp_step_generator_chk.sv =====
`timescale 1ns / 1ps
module dual_stepper_ramp_step_generator_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          ticks_seen_o
);

  typedef struct {
    longint period;
    longint phase;
    longint speed;
    longint hold;
    bit     dir;
    bit     step;
  } motor_t;

  motor_t pan_m, tilt_m;
  longint ramp_cnt;
  dsrsg_pkg::cfg_t regs;
  logic [39:0] levels_q[$];

  function automatic void pulse(ref motor_t a);
    if (a.hold > 0) begin
      a.hold--;
      a.step = 1'b0;
    end else if (a.period > 0) begin
      if (a.phase == 0) a.step = 1'b1;
      else if (a.phase == 1) a.step = 1'b0;
      a.phase++;
      if (a.phase >= a.period) a.phase = 0;
    end
  endfunction

  function automatic void ramp(ref motor_t a, input longint tgt, input bit inv);
    longint lim, nxt, diff, stp, mag, p;
    bit d;
    lim = longint'(regs.max_velocity);
    if ((a.speed > 0 && tgt < 0) || (a.speed < 0 && tgt > 0)) tgt = 0;
    if (a.speed == tgt) return;
    diff = tgt - a.speed;
    stp = diff > 0 ? longint'(regs.accel_step) : -longint'(regs.accel_step);
    if ((diff > 0 && stp > diff) || (diff < 0 && stp < diff)) stp = diff;
    nxt = a.speed + stp;
    if ((a.speed > 0 && nxt < 0) || (a.speed < 0 && nxt > 0)) nxt = 0;
    if (nxt > lim) nxt = lim;
    if (nxt < -lim) nxt = -lim;
    a.speed = nxt;
    if (nxt == 0) begin
      a.period = 0;
      a.phase = 0;
      a.step = 1'b0;
    end else begin
      d = (nxt > 0) ^ inv;
      mag = nxt > 0 ? nxt : -nxt;
      if (d != a.dir) begin
        a.step = 1'b0;
        a.phase = 0;
        a.hold = longint'(regs.setup_hold);
      end
      a.dir = d;
      p = (longint'(regs.step_rate) + mag / 2) / mag;
      if (p < 2) p = 2;
      a.period = p & 20'hFFFFF;
      if (a.phase >= a.period) a.phase = 0;
    end
  endfunction

  function automatic logic [39:0] advance_tick(logic [39:0] din);
    longint pt, tt;
    logic [16:0] pv, tv;
    pt = longint'($signed(din[16:0]));
    tt = longint'($signed(din[33:17]));
    if (din[34]) begin
      pan_m.speed = 0; tilt_m.speed = 0;
      pan_m.period = 0; tilt_m.period = 0;
      pan_m.step = 1'b0; tilt_m.step = 1'b0;
      pt = 0; tt = 0;
    end
    pulse(pan_m);
    pulse(tilt_m);
    ramp_cnt = (ramp_cnt + 1) & 16'hFFFF;
    if (ramp_cnt >= longint'(regs.ramp_divider)) begin
      ramp_cnt = 0;
      ramp(pan_m, pt, regs.pan_invert);
      ramp(tilt_m, tt, regs.tilt_invert);
    end
    pv = pan_m.speed[16:0];
    tv = tilt_m.speed[16:0];
    return {6'd0, tv, pv, tilt_m.dir, tilt_m.step, pan_m.dir, pan_m.step};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [39:0] exp_v;
    if (!rst_ni) begin
      pan_m = '{default: 0};
      tilt_m = '{default: 0};
      ramp_cnt = 0;
      regs.max_velocity = 16'd20000;
      regs.step_rate = 20'd100000;
      regs.accel_step = 10'd1;
      regs.ramp_divider = 16'd20;
      regs.setup_hold = 8'd5;
      regs.pan_invert = 1'b0;
      regs.tilt_invert = 1'b1;
      levels_q.delete();
      fail_count_o <= 0;
      ticks_seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dsrsg_pkg::RegMaxVelocity: regs.max_velocity = cfg_data_i[15:0];
          dsrsg_pkg::RegStepRate:    regs.step_rate = cfg_data_i;
          dsrsg_pkg::RegAccelStep:   regs.accel_step = cfg_data_i[9:0];
          dsrsg_pkg::RegRampDivider: regs.ramp_divider = cfg_data_i[15:0];
          dsrsg_pkg::RegDirSetup:    regs.setup_hold = cfg_data_i[7:0];
          dsrsg_pkg::RegPanInvert:   regs.pan_invert = cfg_data_i[0];
          dsrsg_pkg::RegTiltInvert:  regs.tilt_invert = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) levels_q.push_back(advance_tick(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        ticks_seen_o <= ticks_seen_o + 1;
        if (levels_q.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = levels_q.pop_front();
          if (exp_v[0] !== m_axis_tdata[0])
            $error("pan_step exp %0d got %0d", exp_v[0], m_axis_tdata[0]);
          if (exp_v[1] !== m_axis_tdata[1])
            $error("pan_dir exp %0d got %0d", exp_v[1], m_axis_tdata[1]);
          if (exp_v[2] !== m_axis_tdata[2])
            $error("tilt_step exp %0d got %0d", exp_v[2], m_axis_tdata[2]);
          if (exp_v[3] !== m_axis_tdata[3])
            $error("tilt_dir exp %0d got %0d", exp_v[3], m_axis_tdata[3]);
          if (exp_v[20:4] !== m_axis_tdata[20:4])
            $error("pan_velocity exp %0d got %0d",
                   $signed(exp_v[20:4]), $signed(m_axis_tdata[20:4]));
          if (exp_v[37:21] !== m_axis_tdata[37:21])
            $error("tilt_velocity exp %0d got %0d",
                   $signed(exp_v[37:21]), $signed(m_axis_tdata[37:21]));
          if (exp_v[37:0] !== m_axis_tdata[37:0]) fail_count_o <= fail_count_o + 1;
        end
      end
      pending_o <= levels_q.size();
    end
  end

endmodule

// ===== tb/dual_stepper_ramp_step_generator_tb.sv =====
`timescale 1ns / 1ps
module dual_stepper_ramp_step_generator_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  int          fail_count, pending, ticks_seen;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_off = 0;
  int          sent = 0, cfg_sets = 0, idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dual_stepper_ramp_step_generator u_top (.*);

  dual_stepper_ramp_step_generator_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .ticks_seen_o(ticks_seen)
  );

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_tick(logic signed [16:0] pt, logic signed [16:0] tt, bit hs);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, hs, tt, pt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic signed [16:0] pick_target(int lim);
    case ($urandom_range(9))
      0: return 17'sd50000;
      1: return -17'sd50000;
      2: return '0;
      3: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(2 * lim) - lim);
    endcase
  endfunction

  task automatic apply_setting(int sel);
    case (sel)
      0: begin
        write_reg(dsrsg_pkg::RegMaxVelocity, 20'd50000);
        write_reg(dsrsg_pkg::RegStepRate, 20'd1000000);
        write_reg(dsrsg_pkg::RegAccelStep, 20'd1000);
        write_reg(dsrsg_pkg::RegRampDivider, 20'd1);
        write_reg(dsrsg_pkg::RegDirSetup, 20'd255);
        write_reg(dsrsg_pkg::RegPanInvert, 20'd1);
        write_reg(dsrsg_pkg::RegTiltInvert, 20'd0);
      end
      1: begin
        write_reg(dsrsg_pkg::RegMaxVelocity, 20'd1);
        write_reg(dsrsg_pkg::RegStepRate, 20'd1);
        write_reg(dsrsg_pkg::RegAccelStep, 20'd1);
        write_reg(dsrsg_pkg::RegRampDivider, 20'd3);
        write_reg(dsrsg_pkg::RegDirSetup, 20'd0);
        write_reg(dsrsg_pkg::RegPanInvert, 20'd0);
        write_reg(dsrsg_pkg::RegTiltInvert, 20'd1);
      end
      2: begin
        write_reg(dsrsg_pkg::RegMaxVelocity, 20'd0);
        write_reg(dsrsg_pkg::RegAccelStep, 20'd0);
        write_reg(dsrsg_pkg::RegRampDivider, 20'd0);
      end
      3: begin
        write_reg(dsrsg_pkg::RegMaxVelocity, 20'd65535);
        write_reg(dsrsg_pkg::RegStepRate, 20'hFFFFF);
        write_reg(dsrsg_pkg::RegAccelStep, 20'd1023);
        write_reg(dsrsg_pkg::RegRampDivider, 20'd2);
        write_reg(dsrsg_pkg::RegDirSetup, 20'd3);
      end
      default: begin
        write_reg(dsrsg_pkg::RegMaxVelocity, 20'($urandom_range(50000, 1)));
        write_reg(dsrsg_pkg::RegStepRate, 20'($urandom_range(1000000, 1)));
        write_reg(dsrsg_pkg::RegAccelStep, 20'($urandom_range(1000, 1)));
        write_reg(dsrsg_pkg::RegRampDivider, 20'($urandom_range(4, 1)));
        write_reg(dsrsg_pkg::RegDirSetup, 20'($urandom_range(255)));
        write_reg(dsrsg_pkg::RegPanInvert, 20'($urandom_range(1)));
        write_reg(dsrsg_pkg::RegTiltInvert, 20'($urandom_range(1)));
      end
    endcase
    cfg_sets++;
  endtask

  initial begin
    int lim;
    logic signed [16:0] pt, tt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ramp toward extremes, reverse, hard stop
    apply_setting(0);
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: send_tick(17'sd50000, -17'sd50000, 1'b0);
        1: send_tick(-17'sd50000, 17'sd50000, 1'b0);
        2: send_tick(17'sd1, -17'sd1, 1'b0);
        3: send_tick(17'sd50000, 17'sd50000, 1'b1);
        4: send_tick(-17'sh10000, 17'sh0FFFF, 1'b0);
        default: send_tick('0, '0, 1'b0);
      endcase
    end
    drain_block();

    for (int ph = 0; ph < 9; ph++) begin
      apply_setting(ph < 4 ? ph : 4);
      if (ph < 3) begin send_idle = 35; recv_idle = 60; end
      else if (ph < 6) begin send_idle = 60; recv_idle = 35; end
      else begin send_idle = 0; recv_idle = 0; end
      lim = $urandom_range(1) ? 60000 : 600;
      pt = pick_target(lim);
      tt = pick_target(lim);
      if (ph == 6) fork
        begin hold_off = 1; repeat (300) @(posedge clk_i); hold_off = 0; end
      join_none
      for (int k = 0; k < 203; k++) begin
        if ($urandom_range(15) == 0) begin pt = pick_target(lim); tt = pick_target(lim); end
        send_tick(pt, tt, $urandom_range(40) == 0);
      end
      drain_block();
    end
    repeat (50) @(posedge clk_i);
    $display("Ran %0d ticks over %0d register settings, %0d results checked.",
             sent, cfg_sets, ticks_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dsrsg_pkg.sv
hdl/dsrsg_ctrl.sv
hdl/dsrsg_axis.sv
hdl/dsrsg_datapath.sv
hdl/dual_stepper_ramp_step_generator.sv
tb/dual_stepper_ramp_step_generator_chk.sv
tb/dual_stepper_ramp_step_generator_tb.sv
